/* sv/mtet_pkg.sv */
// Shared constants, result codes and controller/datapath interface types.
package mtet_pkg;

  localparam int unsigned TIMERS_DEF = 16;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned MS_W   = 32;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CMD_W  = 2;

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED   = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_NONE      = 3'd4
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic create;
    logic start;
    logic step;
    logic finish;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic remain_zero;
    logic eval_push;
    logic out_free;
  } dp_sts_t;

endpackage

/* sv/mtet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mtet_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mtet_ctrl.sv */
// Sequencing state machine for create, cancel walk and tick walk.
module mtet_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mtet_pkg::CMD_W-1:0]  cmd_i,
  input  mtet_pkg::dp_sts_t           sts_i,
  output mtet_pkg::dp_ctl_t           ctl_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CREATE = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          if (cmd_i == mtet_pkg::CMD_CREATE) begin
            state_d = ST_CREATE;
          end else if (cmd_i inside {mtet_pkg::CMD_CANCEL, mtet_pkg::CMD_TICK}) begin
            state_d = ST_START;
          end
        end
      end
      ST_CREATE: begin
        if (sts_i.out_free) begin
          ctl_o.create = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_START: begin
        if (sts_i.count_zero) begin
          state_d = ST_FINISH;
        end else begin
          ctl_o.start = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold the entry while an earlier expiry waits for the output
        if (!sts_i.eval_push || sts_i.out_free) begin
          ctl_o.step = 1'b1;
          if (sts_i.remain_zero) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/mtet_dp.sv */
// Timer list datapath: circular age-ordered table, walk pointers, result register.
module mtet_dp #(
  parameter int unsigned TIMERS = mtet_pkg::TIMERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mtet_pkg::TICK_W-1:0]  cfg_wdata_i,
  input  logic [mtet_pkg::CMD_W-1:0]   cmd_i,
  input  logic [mtet_pkg::ID_W-1:0]    timer_id_i,
  input  logic [mtet_pkg::MS_W-1:0]    duration_ms_i,
  input  mtet_pkg::dp_ctl_t            ctl_i,
  output mtet_pkg::dp_sts_t            sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [mtet_pkg::KIND_W-1:0]  kind_o,
  output logic [mtet_pkg::ID_W-1:0]    expired_id_o,
  output logic [mtet_pkg::CNT_W-1:0]   cancelled_count_o,
  output logic                         last_o
);

  localparam int unsigned IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned CW = $clog2(TIMERS + 1);
  localparam int unsigned EW = mtet_pkg::ID_W + mtet_pkg::MS_W;

  function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
    ptr_dec = (p == '0) ? IW'(TIMERS - 1) : p - 1'b1;
  endfunction

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(TIMERS - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [mtet_pkg::TICK_W-1:0] ms_per_tick_q;
  logic                        is_tick_q;
  logic [mtet_pkg::ID_W-1:0]   id_q;
  logic [mtet_pkg::MS_W-1:0]   dur_q;
  logic [CW-1:0]               count_q, remain_q, kept_q, removed_q;
  logic [IW-1:0]               head_q, rp_q, wp_q;
  logic                        held_v_q;
  logic [mtet_pkg::ID_W-1:0]   held_id_q;

  logic                        out_valid_q;
  mtet_pkg::kind_e             kind_q;
  logic [mtet_pkg::ID_W-1:0]   exp_id_q;
  logic [mtet_pkg::CNT_W-1:0]  cnt_q;
  logic                        last_q;

  logic [CW:0]                 sum;
  logic [IW-1:0]               tail_free, walk_first;
  logic [EW-1:0]               rdata;
  logic [mtet_pkg::ID_W-1:0]   elem_id;
  logic [mtet_pkg::MS_W-1:0]   elem_rem, tick_ext, keep_rem;
  logic                        drop, full, out_free, push;
  logic                        we, re;
  logic [IW-1:0]               waddr, raddr;
  logic [EW-1:0]               wdata;

  // Table occupies head..head+count-1 (mod TIMERS), oldest at head.
  assign sum        = {1'b0, CW'(head_q)} + {1'b0, count_q};
  assign tail_free  = (sum >= (CW + 1)'(TIMERS)) ? IW'(sum - (CW + 1)'(TIMERS)) : IW'(sum);
  assign walk_first = ptr_dec(tail_free);

  assign elem_id  = rdata[EW-1:mtet_pkg::MS_W];
  assign elem_rem = rdata[mtet_pkg::MS_W-1:0];
  assign tick_ext = mtet_pkg::MS_W'(ms_per_tick_q);
  assign drop     = is_tick_q ? (elem_rem <= tick_ext) : (elem_id == id_q);
  assign keep_rem = is_tick_q ? (elem_rem - tick_ext) : elem_rem;
  assign full     = (count_q == CW'(TIMERS));
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.count_zero  = (count_q == '0);
  assign sts_o.remain_zero = (remain_q == '0);
  assign sts_o.eval_push   = is_tick_q && drop && held_v_q;
  assign sts_o.out_free    = out_free;

  // Survivors are rewritten downward behind the read pointer.
  assign we    = (ctl_i.create && !full) || (ctl_i.step && !drop);
  assign waddr = ctl_i.create ? tail_free : wp_q;
  assign wdata = ctl_i.create ? {id_q, dur_q} : {elem_id, keep_rem};
  assign re    = ctl_i.start || (ctl_i.step && (remain_q != '0));
  assign raddr = ctl_i.start ? walk_first : ptr_dec(rp_q);

  mtet_ram #(
    .WIDTH (EW),
    .DEPTH (TIMERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_tick_q <= mtet_pkg::TICK_RESET;
      count_q       <= '0;
      head_q        <= '0;
      held_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ms_per_tick_q <= cfg_wdata_i;
      end
      if (ctl_i.capture) begin
        held_v_q <= 1'b0;
      end
      if (ctl_i.create && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (ctl_i.step && drop && is_tick_q) begin
        held_v_q <= 1'b1;
      end
      if (ctl_i.finish) begin
        count_q <= kept_q;
        // an empty table is never walked; leave head where it is
        if (count_q != '0) begin
          head_q <= ptr_inc(wp_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      is_tick_q <= (cmd_i == mtet_pkg::CMD_TICK);
      id_q      <= timer_id_i;
      dur_q     <= duration_ms_i;
      kept_q    <= '0;
      removed_q <= '0;
    end
    if (ctl_i.start) begin
      rp_q     <= walk_first;
      wp_q     <= walk_first;
      remain_q <= count_q - 1'b1;
    end
    if (ctl_i.step) begin
      if (!drop) begin
        wp_q   <= ptr_dec(wp_q);
        kept_q <= kept_q + 1'b1;
      end else if (!is_tick_q) begin
        removed_q <= removed_q + 1'b1;
      end else begin
        held_id_q <= elem_id;
      end
      if (remain_q != '0) begin
        rp_q     <= ptr_dec(rp_q);
        remain_q <= remain_q - 1'b1;
      end
    end
  end

  // Result register: an expiry is held back one step so the final one carries last.
  assign push = ctl_i.create || ctl_i.finish || (ctl_i.step && sts_o.eval_push);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      exp_id_q <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b1;
      if (ctl_i.create) begin
        kind_q <= full ? mtet_pkg::KIND_FULL : mtet_pkg::KIND_CREATED;
      end else if (ctl_i.step) begin
        kind_q   <= mtet_pkg::KIND_EXPIRED;
        exp_id_q <= held_id_q;
        last_q   <= 1'b0;
      end else if (!is_tick_q) begin
        kind_q <= mtet_pkg::KIND_CANCELLED;
        cnt_q  <= mtet_pkg::CNT_W'(removed_q);
      end else if (held_v_q) begin
        kind_q   <= mtet_pkg::KIND_EXPIRED;
        exp_id_q <= held_id_q;
      end else begin
        kind_q <= mtet_pkg::KIND_NONE;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign expired_id_o      = exp_id_q;
  assign cancelled_count_o = cnt_q;
  assign last_o            = last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TIMERS))
    else $error("timer count exceeds table depth");

  a_kept_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step |-> kept_q < count_q)
    else $error("walk kept more entries than the table holds");

  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed over a waiting result");

  a_no_clobber : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && we && re) |-> (waddr != raddr))
    else $error("walk rewrite hits the entry being read next");

endmodule

/* sv/multi_timer_expiry_table.sv */
// Top level of the one-shot multi-timer expiry table.
// Sequence: a create's result is registered once the output is free; a cancel or tick walks
//   all N timers held and registers its last result at the finish step.
// Accepts no new item until the previous one is finished; output stalls hold it up too. The
//   table walk runs at one entry per cycle unless an expiry waits for the output.
// Reset: table empty, ms_per_tick = 1, output empty; the table RAM needs no clearing pass.
module multi_timer_expiry_table #(
  parameter int unsigned TIMERS = mtet_pkg::TIMERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: ms_per_tick
  input  logic                         cfg_we_i,
  input  logic [mtet_pkg::TICK_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mtet_pkg::CMD_W-1:0]   cmd_i,
  input  logic [mtet_pkg::ID_W-1:0]    timer_id_i,
  input  logic [mtet_pkg::MS_W-1:0]    duration_ms_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mtet_pkg::KIND_W-1:0]  kind_o,
  output logic [mtet_pkg::ID_W-1:0]    expired_id_o,
  output logic [mtet_pkg::CNT_W-1:0]   cancelled_count_o,
  output logic                         last_o
);

  // Controller and datapath talk only through these two bundles.
  mtet_pkg::dp_ctl_t ctl;
  mtet_pkg::dp_sts_t sts;

  // Sequence each item: capture, then create, or walk the table and finish.
  mtet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Table storage, walk arithmetic and the result register.
  mtet_dp #(
    .TIMERS (TIMERS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_i),
    .timer_id_i        (timer_id_i),
    .duration_ms_i     (duration_ms_i),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .expired_id_o      (expired_id_o),
    .cancelled_count_o (cancelled_count_o),
    .last_o            (last_o)
  );

endmodule

/* test/multi_timer_expiry_table_tb.sv */
// Self-checking testbench for the one-shot multi-timer expiry table.
module multi_timer_expiry_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMERS = mtet_pkg::TIMERS_DEF;
  localparam int unsigned ID_W   = mtet_pkg::ID_W;
  localparam int unsigned MS_W   = mtet_pkg::MS_W;
  localparam int unsigned TICK_W = mtet_pkg::TICK_W;
  localparam int unsigned KIND_W = mtet_pkg::KIND_W;
  localparam int unsigned CNT_W  = mtet_pkg::CNT_W;
  localparam int unsigned CMD_W  = mtet_pkg::CMD_W;

  localparam logic [CMD_W-1:0] CMD_CREATE = mtet_pkg::CMD_CREATE;
  localparam logic [CMD_W-1:0] CMD_CANCEL = mtet_pkg::CMD_CANCEL;
  localparam logic [CMD_W-1:0] CMD_TICK   = mtet_pkg::CMD_TICK;

  localparam mtet_pkg::kind_e KIND_CREATED   = mtet_pkg::KIND_CREATED;
  localparam mtet_pkg::kind_e KIND_FULL      = mtet_pkg::KIND_FULL;
  localparam mtet_pkg::kind_e KIND_CANCELLED = mtet_pkg::KIND_CANCELLED;
  localparam mtet_pkg::kind_e KIND_EXPIRED   = mtet_pkg::KIND_EXPIRED;
  localparam mtet_pkg::kind_e KIND_NONE      = mtet_pkg::KIND_NONE;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TICK_W-1:0] TICK_TOP = 10'd1023;
  localparam int unsigned PHASE_ITEMS = 13;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = TIMERS + 8;
  // Longest quiet stretch is the receiver hold plus a drain pause.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // One result item as the block reports it.
  typedef struct packed {
    mtet_pkg::kind_e  kind;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } timer_result_t;

  // One row of the directed table: either a tick-length write or an item,
  // optionally repeated, optionally with its single result typed in.
  typedef struct {
    logic              is_cfg;
    logic [TICK_W-1:0] cfg_val;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [MS_W-1:0]   dur;
    int unsigned       reps;
    logic              typed;
    mtet_pkg::kind_e   t_kind;
    logic [CNT_W-1:0]  t_cnt;
  } step_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd;
  logic [ID_W-1:0]   timer_id;
  logic [MS_W-1:0]   duration_ms;
  logic              out_valid_o;
  logic              out_ready;
  logic [KIND_W-1:0] kind_o;
  logic [ID_W-1:0]   expired_id_o;
  logic [CNT_W-1:0]  cancelled_count_o;
  logic              last_o;

  // Shadow copy of the table and the tick length.
  logic              slot_used [TIMERS];
  logic [ID_W-1:0]   slot_tid  [TIMERS];
  logic [MS_W-1:0]   slot_left [TIMERS];
  int unsigned       slot_rank [TIMERS];
  logic [TICK_W-1:0] tick_ms;

  timer_result_t new_results[$];
  timer_result_t awaited[$];
  step_row_t     plan[$];
  logic [ID_W-1:0] id_pool[4];

  int unsigned errors;
  bit          calm;
  int unsigned hold_asks;
  int unsigned hold_done;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned run_left;

  multi_timer_expiry_table #(
    .TIMERS(TIMERS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd),
    .timer_id_i       (timer_id),
    .duration_ms_i    (duration_ms),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .kind_o           (kind_o),
    .expired_id_o     (expired_id_o),
    .cancelled_count_o(cancelled_count_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Expiry predictor
  // ------------------------------------------------------------------

  function automatic void note_result(mtet_pkg::kind_e kind, logic [ID_W-1:0] id,
                                      logic [CNT_W-1:0] cnt);
    timer_result_t r;
    r.kind = kind;
    r.id   = id;
    r.cnt  = cnt;
    r.last = 1'b0;
    new_results.push_back(r);
  endfunction

  // Renumber the ages of live timers to 0..n-1, keeping their order.
  function automatic void rerank_slots();
    int unsigned fresh [TIMERS];
    for (int i = 0; i < TIMERS; i++) begin
      fresh[i] = 0;
      if (slot_used[i]) begin
        for (int j = 0; j < TIMERS; j++) begin
          if (slot_used[j] && slot_rank[j] < slot_rank[i]) fresh[i]++;
        end
      end
    end
    for (int i = 0; i < TIMERS; i++) begin
      if (slot_used[i]) slot_rank[i] = fresh[i];
    end
  endfunction

  // Apply one item to the shadow table; its results land in new_results.
  function automatic void predict_item(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                       logic [MS_W-1:0] dur);
    int            free_slot;
    int unsigned   removed;
    timer_result_t tail;
    new_results.delete();
    case (c)
      CMD_CREATE: begin
        free_slot = -1;
        for (int i = 0; i < TIMERS; i++) begin
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          note_result(KIND_FULL, '0, '0);
        end else begin
          for (int i = 0; i < TIMERS; i++) begin
            if (slot_used[i]) slot_rank[i]++;
          end
          slot_used[free_slot] = 1'b1;
          slot_tid[free_slot]  = id;
          slot_left[free_slot] = dur;
          slot_rank[free_slot] = 0;
          note_result(KIND_CREATED, '0, '0);
        end
      end
      CMD_CANCEL: begin
        removed = 0;
        for (int i = 0; i < TIMERS; i++) begin
          if (slot_used[i] && slot_tid[i] == id) begin
            slot_used[i] = 1'b0;
            removed++;
          end
        end
        rerank_slots();
        note_result(KIND_CANCELLED, '0, CNT_W'(removed));
      end
      CMD_TICK: begin
        // Report newest first, then retire or count down.
        for (int a = 0; a < TIMERS; a++) begin
          for (int i = 0; i < TIMERS; i++) begin
            if (slot_used[i] && slot_rank[i] == a && slot_left[i] <= MS_W'(tick_ms))
              note_result(KIND_EXPIRED, slot_tid[i], '0);
          end
        end
        for (int i = 0; i < TIMERS; i++) begin
          if (slot_used[i]) begin
            if (slot_left[i] <= MS_W'(tick_ms)) slot_used[i] = 1'b0;
            else slot_left[i] = slot_left[i] - MS_W'(tick_ms);
          end
        end
        rerank_slots();
        if (new_results.size() == 0) note_result(KIND_NONE, '0, '0);
      end
      default: return;
    endcase
    tail = new_results.pop_back();
    tail.last = 1'b1;
    new_results.push_back(tail);
  endfunction

  // ------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------

  // Offer one item from a rising edge, return at the edge that takes it.
  task automatic send_item(logic [CMD_W-1:0] c, logic [ID_W-1:0] id, logic [MS_W-1:0] dur,
                           logic typed, timer_result_t typed_res);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    timer_id    <= id;
    duration_ms <= dur;
    // Ready is stable between edges; sample it mid-cycle.
    do @(negedge clk_i); while (!in_ready_o);
    predict_item(c, id, dur);
    if (typed) awaited.push_back(typed_res);
    else foreach (new_results[k]) awaited.push_back(new_results[k]);
    @(posedge clk_i);
  endtask

  // Drop valid, let every result drain and the walk finish, then set the tick length.
  task automatic set_tick_when_idle(logic [TICK_W-1:0] val);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    tick_ms    = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic step_row_t mk_row(logic is_cfg, logic [TICK_W-1:0] cfg_val,
                                       logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                       logic [MS_W-1:0] dur, int unsigned reps,
                                       logic typed, mtet_pkg::kind_e t_kind,
                                       logic [CNT_W-1:0] t_cnt);
    step_row_t r;
    r.is_cfg  = is_cfg;
    r.cfg_val = cfg_val;
    r.cmd     = c;
    r.id      = id;
    r.dur     = dur;
    r.reps    = reps;
    r.typed   = typed;
    r.t_kind  = t_kind;
    r.t_cnt   = t_cnt;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_id(int unsigned pool_pct);
    if ($urandom_range(1, 100) <= pool_pct) return id_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Durations cluster around the tick length so timers expire often;
  // huge ones go to pooled ids so that a cancel can still free them.
  task automatic pick_create(output logic [ID_W-1:0] id, output logic [MS_W-1:0] dur);
    int unsigned r;
    r = $urandom_range(0, 99);
    id = pick_id(60);
    if (r < 15) dur = '0;
    else if (r < 45) dur = $urandom_range(0, tick_ms);
    else if (r < 85) dur = $urandom_range(0, 4 * tick_ms + 4);
    else begin
      dur = $urandom;
      id  = id_pool[$urandom_range(0, 3)];
    end
  endtask

  // ------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold on request
  // ------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_asks != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 30) - 1;
      out_ready <= 1'b1;
    end
  end

  // Check each result mid-cycle; it is taken at the next rising edge.
  always @(negedge clk_i) begin
    timer_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result item: kind %0d id %0h count %0d last %0b",
               kind_o, expired_id_o, cancelled_count_o, last_o);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          errors++;
        end
        if (expired_id_o !== want.id) begin
          $error("expired_id: expected %0h, got %0h", want.id, expired_id_o);
          errors++;
        end
        if (cancelled_count_o !== want.cnt) begin
          $error("cancelled_count: expected %0d, got %0d", want.cnt, cancelled_count_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // End the run if no item moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------

  initial begin : main
    timer_result_t     typed_res;
    step_row_t         row;
    logic [TICK_W-1:0] phase_tick [5];
    logic [ID_W-1:0]   id;
    logic [MS_W-1:0]   dur;
    int unsigned       sent;
    int unsigned       pick;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    cmd         = '0;
    timer_id    = '0;
    duration_ms = '0;
    out_ready   = 1'b0;
    errors      = 0;
    calm        = 1'b0;
    hold_asks   = 0;
    hold_done   = 0;
    hold_left   = 0;
    stall_left  = 0;
    run_left    = 0;
    tick_ms     = mtet_pkg::TICK_RESET;
    for (int i = 0; i < TIMERS; i++) begin
      slot_used[i] = 1'b0;
      slot_tid[i]  = '0;
      slot_left[i] = '0;
      slot_rank[i] = 0;
    end
    foreach (id_pool[k]) id_pool[k] = $urandom;

    // Directed table. Typed rows carry their one obvious result.
    // Empty table: tick gives none, cancel removes nothing, cmd 3 is dropped.
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 1, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CANCEL, '0, '0, 1, 1, KIND_CANCELLED, '0));
    plan.push_back(mk_row(0, '0, CMD_UNUSED, '1, '1, 1, 0, KIND_NONE, '0));
    // Field extremes, zero duration, duplicate ids; tick reports newest first.
    plan.push_back(mk_row(0, '0, CMD_CREATE, '0, '0, 1, 1, KIND_CREATED, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, '1, '1, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'h5, 32'd2, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'h5, 32'd1, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CANCEL, 32'h5, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CANCEL, 32'h1234_5678, '0, 1, 1, KIND_CANCELLED, '0));
    // Zero tick length: only timers already at zero expire.
    plan.push_back(mk_row(1, '0, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'h77, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));
    // Largest tick length, expiry exactly at the boundary.
    plan.push_back(mk_row(1, TICK_TOP, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'hA5A5_A5A5, 32'd1023, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'h5A5A_5A5A, 32'd1024, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CANCEL, '1, '0, 1, 0, KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CANCEL, 32'h5A5A_5A5A, '0, 1, 0, KIND_NONE, '0));
    // Full table, then a cancel that clears all sixteen.
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'hC0FF_EE00, 32'd500, TIMERS, 0,
                          KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'h1, 32'd1, 1, 1, KIND_FULL, '0));
    plan.push_back(mk_row(0, '0, CMD_CANCEL, 32'hC0FF_EE00, '0, 1, 1, KIND_CANCELLED,
                          CNT_W'(TIMERS)));
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 1, KIND_NONE, '0));
    // Sixteen expiries from one tick.
    plan.push_back(mk_row(0, '0, CMD_CREATE, 32'h0F0F_0F0F, 32'd1023, TIMERS, 0,
                          KIND_NONE, '0));
    plan.push_back(mk_row(0, '0, CMD_TICK, '0, '0, 1, 0, KIND_NONE, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      row = plan[r];
      if (row.is_cfg) begin
        set_tick_when_idle(row.cfg_val);
      end else begin
        typed_res.kind = row.t_kind;
        typed_res.id   = '0;
        typed_res.cnt  = row.t_cnt;
        typed_res.last = 1'b1;
        repeat (row.reps) send_item(row.cmd, row.id, row.dur, row.typed, typed_res);
      end
    end

    // Random phases, each at its own tick length; the last one runs without idling.
    phase_tick[0] = 10'd1;
    phase_tick[1] = '0;
    phase_tick[2] = TICK_TOP;
    phase_tick[3] = TICK_W'($urandom_range(1, 1000));
    phase_tick[4] = 10'd1000;
    typed_res = '0;
    for (int p = 0; p < 5; p++) begin
      set_tick_when_idle(phase_tick[p]);
      if (p == 4) calm = 1'b1;
      // Hold the receiver off once while items keep coming.
      if (p == 0) hold_asks++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // Fill past full with short timers, then tick them all away.
          for (int k = 0; k <= TIMERS; k++) begin
            send_item(CMD_CREATE, pick_id(50), $urandom_range(0, tick_ms), 0, typed_res);
          end
          send_item(CMD_TICK, $urandom, $urandom, 0, typed_res);
          sent += TIMERS + 2;
        end else if (pick < 48) begin
          pick_create(id, dur);
          send_item(CMD_CREATE, id, dur, 0, typed_res);
          sent++;
        end else if (pick < 62) begin
          send_item(CMD_CANCEL, pick_id(80), $urandom, 0, typed_res);
          sent++;
        end else if (pick < 95) begin
          send_item(CMD_TICK, $urandom, $urandom, 0, typed_res);
          sent++;
        end else begin
          send_item(CMD_UNUSED, $urandom, $urandom, 0, typed_res);
        end
      end
    end

    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
